FILE: hw/rtl/sha1_pkg.sv
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // byte source for a buffer write
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_MARK = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   typedef struct packed {
      logic       put;
      logic [1:0] src;
      logic       init;
      logic       round;
      logic       fold;
      logic       emit;
      logic       restart;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       len_last;
      logic       out_free;
      logic       word_last;
   } status_type;

   localparam int         NUM_WORDS  = 5;
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;
   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [2:0] LEN_LAST   = 3'd7;
   localparam logic [2:0] WORD_LAST  = 3'd4;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   localparam logic [31:0] INIT_H [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = 32'h5A827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (rnd < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

FILE: hw/rtl/sha1_ctrl.sv
module sha1_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 byte_valid,
   input  logic                 end_of_message,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_MARK  = 3'd4;
   localparam logic [2:0] S_ZERO  = 3'd5;
   localparam logic [2:0] S_LEN   = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] resume_ff, resume_in;

   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (byte_valid) begin
                  cmd.put = 1'b1;
                  cmd.src = sha1_pkg::SRC_DATA;
               end
               if (byte_valid && status.fill == sha1_pkg::FILL_LAST) begin
                  state_in  = S_INIT;
                  resume_in = end_of_message ? S_MARK : S_IDLE;
               end else if (end_of_message) begin
                  state_in = S_MARK;
               end
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = resume_ff;
         end
         S_MARK: begin
            cmd.put = 1'b1;
            cmd.src = sha1_pkg::SRC_MARK;
            if (status.fill == sha1_pkg::FILL_LAST) begin
               state_in  = S_INIT;
               resume_in = S_ZERO;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (status.fill == sha1_pkg::FILL_LEN) begin
               state_in = S_LEN;
            end else begin
               cmd.put = 1'b1;
               cmd.src = sha1_pkg::SRC_ZERO;
               if (status.fill == sha1_pkg::FILL_LAST) begin
                  state_in  = S_INIT;
                  resume_in = S_ZERO;
               end
            end
         end
         S_LEN: begin
            cmd.put = 1'b1;
            cmd.src = sha1_pkg::SRC_LEN;
            if (status.len_last) begin
               state_in  = S_INIT;
               resume_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.word_last) begin
                  cmd.restart = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resume_ff <= S_IDLE;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
      end
   end

endmodule

FILE: hw/rtl/sha1_dp.sv
module sha1_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           data_byte,
   input  sha1_pkg::cmd_type    cmd,
   output sha1_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sha1_pkg::rsp_type    rsp_payload
);

   logic [31:0]  chain_ff [sha1_pkg::NUM_WORDS];
   logic [31:0]  chain_in [sha1_pkg::NUM_WORDS];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [511:0] sched_ff, sched_in;
   logic [63:0]  count_ff, count_in;
   logic [5:0]   fill_ff, fill_in;
   logic [6:0]   round_ff, round_in;
   logic [2:0]   len_ff, len_in;
   logic [2:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   sha1_pkg::rsp_type out_ff, out_in;

   logic [63:0]  bit_len;
   logic [7:0]   put_val;
   logic [31:0]  w0, w_next, temp, word_sel;

   assign bit_len = {count_ff[60:0], 3'b000};
   assign w0      = sched_ff[511:480];
   assign w_next  = sched_ff[95:64] ^ sched_ff[255:224] ^ sched_ff[447:416] ^ w0;
   assign temp    = {a_ff[26:0], a_ff[31:27]} + sha1_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                    + e_ff + sha1_pkg::round_k(round_ff) + w0;

   always_comb begin
      unique case (cmd.src)
         sha1_pkg::SRC_DATA: put_val = data_byte;
         sha1_pkg::SRC_MARK: put_val = sha1_pkg::PAD_MARK;
         sha1_pkg::SRC_ZERO: put_val = 8'h00;
         default:            put_val = bit_len[{~len_ff, 3'b000} +: 8];
      endcase
   end

   always_comb begin
      case (idx_ff)
         3'd0:    word_sel = chain_ff[0];
         3'd1:    word_sel = chain_ff[1];
         3'd2:    word_sel = chain_ff[2];
         3'd3:    word_sel = chain_ff[3];
         default: word_sel = chain_ff[4];
      endcase
   end

   always_comb begin
      chain_in = chain_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      sched_in = sched_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      out_in   = out_ff;

      if (cmd.put) begin
         sched_in = {sched_ff[503:0], put_val};
         fill_in  = fill_ff + 6'd1;
         if (cmd.src == sha1_pkg::SRC_DATA) begin
            count_in = count_ff + 64'd1;
         end
         if (cmd.src == sha1_pkg::SRC_LEN) begin
            len_in = len_ff + 3'd1;
         end
      end
      if (cmd.init) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = '0;
      end
      if (cmd.round) begin
         a_in     = temp;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         sched_in = {sched_ff[479:0], w_next[30:0], w_next[31]};
         round_in = round_ff + 7'd1;
      end
      if (cmd.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
      if (cmd.emit) begin
         valid_in           = 1'b1;
         out_in.digest_word = word_sel;
         out_in.word_index  = idx_ff;
         out_in.last_word   = (idx_ff == sha1_pkg::WORD_LAST);
         idx_in             = idx_ff + 3'd1;
      end
      if (cmd.restart) begin
         chain_in = sha1_pkg::INIT_H;
         count_in = '0;
         fill_in  = '0;
         len_in   = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1_pkg::INIT_H;
         count_ff <= '0;
         fill_ff  <= '0;
         round_ff <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      sched_ff <= sched_in;
      out_ff   <= out_in;
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == sha1_pkg::ROUND_LAST);
   assign status.len_last   = (len_ff == sha1_pkg::LEN_LAST);
   assign status.out_free   = !valid_ff || !rsp_stall;
   assign status.word_last  = (idx_ff == sha1_pkg::WORD_LAST);
   assign rsp_valid         = valid_ff;
   assign rsp_payload       = out_ff;

endmodule

FILE: hw/rtl/sha1_hash_engine_top.sv
// SHA-1 engine over a byte stream. Each req_ transfer carries at most one
// message byte (byte_valid) and may close the message (end_of_message); a
// transfer with both absorbs the byte first. Closing a message pads it,
// finishes it and then presents the five digest words on rsp_, word 0 first,
// with last_word on word 4; the engine then starts the next message from the
// initial hash values. A byte that completes a 64-byte block starts the
// compression: a load step, 80 rounds in the single shared round unit,
// then a fold into the chaining words. Closing a message writes the pad
// bytes one per cycle, save while a compression runs, through the same
// buffer path (9 to 72 bytes, plus a step that spots the length slot),
// runs one or two compressions, and hands out the five words one per
// cycle while rsp_stall is low. Sustained streaming is set by the round
// unit, as no new byte is taken while a block compresses.
// req_stall is high whenever the engine is busy with a block, padding or
// the digest; the last digest word may still wait in the output register
// while the next request transfer is taken.
module sha1_hash_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sha1_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sha1_pkg::rsp_type rsp_payload
);

   // commands from the sequencer, status back from the datapath
   sha1_pkg::cmd_type    cmd;
   sha1_pkg::status_type status;

   // sequencer: accept transfers, drive padding, compression and read-out
   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .byte_valid     (req_payload.byte_valid),
      .end_of_message (req_payload.end_of_message),
      .status         (status),
      .cmd            (cmd)
   );

   // datapath: block buffer as a shifting schedule, round unit, chaining
   // words, byte count and the digest output register
   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_payload.data_byte),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hw/rtl/sha1_chk.sv
module sha1_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sha1_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sha1_pkg::rsp_type rsp_payload
);

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.word_index <= sha1_pkg::WORD_LAST)
      else $error("digest word index out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.last_word == (rsp_payload.word_index == sha1_pkg::WORD_LAST))
      else $error("last_word disagrees with word index");

   // words of one digest follow in order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_word |=>
         !rsp_valid || rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1)
      else $error("digest words out of order");

endmodule

bind sha1_hash_engine_top sha1_chk u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
